// ===== rtl/iirdf1_pkg.sv =====
// Shared types and constants for the direct form I IIR filter.
package iirdf1_pkg;

    localparam int ORDER_DEF = 3;
    localparam int SAMP_W    = 32;
    localparam int COEF_W    = 24;
    localparam int NUM_COEF  = 4;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W    = SAMP_W + COEF_W;
    localparam int ACC_W     = 58;
    localparam int QUOT_W    = 33;
    localparam int CMD_W     = 2;

    localparam logic [CMD_W-1:0] CMD_FILTER = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FILL   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COEF_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEN_COEF_0 = 3'd4;

    localparam logic signed [COEF_W-1:0] COEF_ONE = 24'sd65536;

    localparam logic signed [SAMP_W-1:0] SAMP_MAX = 32'sh7fff_ffff;
    localparam logic signed [SAMP_W-1:0] SAMP_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [SAMP_W-1:0] quot;
        logic                     sat;
        logic                     dz;
    } div_res_t;

endpackage

// ===== rtl/iirdf1_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module iirdf1_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 3,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/iirdf1_div.sv =====
// Serial signed divider: truncating quotient, clipped to 32 bits, zero-divisor flag.
module iirdf1_div (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  logic signed [iirdf1_pkg::ACC_W-1:0]    dividend,
    input  logic signed [iirdf1_pkg::COEF_W-1:0]   divisor,
    output logic                                   done,
    output iirdf1_pkg::div_res_t                   res
);

    localparam int AW = iirdf1_pkg::ACC_W;
    localparam int CW = iirdf1_pkg::COEF_W;
    localparam int QW = iirdf1_pkg::QUOT_W;

    typedef enum logic [3:0] {
        D_IDLE = 4'b0001,
        D_CHK  = 4'b0010,
        D_RUN  = 4'b0100,
        D_FIN  = 4'b1000
    } dstate_t;

    dstate_t state_reg, state_next;
    logic [AW-1:0] nmag_reg, nmag_next;
    logic [CW-1:0] dmag_reg, dmag_next;
    logic          neg_reg, neg_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [QW-1:0] sh_reg, sh_next;
    logic [QW-1:0] q_reg, q_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic          done_reg, done_next;
    iirdf1_pkg::div_res_t res_reg, res_next;

    logic [CW:0]   trial;
    logic          ge;
    logic [QW-1:0] q_neg;

    always_comb begin
        state_next = state_reg;
        nmag_next  = nmag_reg;
        dmag_next  = dmag_reg;
        neg_next   = neg_reg;
        rem_next   = rem_reg;
        sh_next    = sh_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        trial      = {rem_reg, sh_reg[QW-1]};
        ge         = (trial >= {1'b0, dmag_reg});
        q_neg      = QW'(~q_reg + 1'b1);

        case (state_reg)
            D_IDLE: begin
                if (start) begin
                    nmag_next  = dividend[AW-1] ? AW'(-dividend) : AW'(dividend);
                    dmag_next  = divisor[CW-1] ? CW'(-divisor) : CW'(divisor);
                    neg_next   = dividend[AW-1] ^ divisor[CW-1];
                    state_next = D_CHK;
                end
            end
            D_CHK: begin
                if (dmag_reg == '0) begin
                    res_next   = '{quot: '0, sat: 1'b0, dz: 1'b1};
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end else if (nmag_reg[AW-1:QW-1] >= {2'b00, dmag_reg}) begin
                    // quotient reaches 2^32 or more: clip without iterating
                    res_next.quot = neg_reg ? iirdf1_pkg::SAMP_MIN : iirdf1_pkg::SAMP_MAX;
                    res_next.sat  = 1'b1;
                    res_next.dz   = 1'b0;
                    done_next     = 1'b1;
                    state_next    = D_IDLE;
                end else begin
                    rem_next   = nmag_reg[AW-2:QW];
                    sh_next    = nmag_reg[QW-1:0];
                    q_next     = '0;
                    cnt_next   = 6'(QW - 1);
                    state_next = D_RUN;
                end
            end
            D_RUN: begin
                rem_next = ge ? CW'(trial - {1'b0, dmag_reg}) : trial[CW-1:0];
                q_next   = {q_reg[QW-2:0], ge};
                sh_next  = {sh_reg[QW-2:0], 1'b0};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == '0) begin
                    state_next = D_FIN;
                end
            end
            D_FIN: begin
                res_next.dz  = 1'b0;
                res_next.sat = 1'b0;
                if (!neg_reg) begin
                    if (q_reg[QW-1] || q_reg[QW-2]) begin
                        res_next.quot = iirdf1_pkg::SAMP_MAX;
                        res_next.sat  = 1'b1;
                    end else begin
                        res_next.quot = q_reg[QW-2:0];
                    end
                end else begin
                    if (q_reg > {2'b01, {(QW-2){1'b0}}}) begin
                        res_next.quot = iirdf1_pkg::SAMP_MIN;
                        res_next.sat  = 1'b1;
                    end else begin
                        res_next.quot = q_neg[QW-2:0];
                    end
                end
                done_next  = 1'b1;
                state_next = D_IDLE;
            end
            default: begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        nmag_reg <= nmag_next;
        dmag_reg <= dmag_next;
        neg_reg  <= neg_next;
        rem_reg  <= rem_next;
        sh_reg   <= sh_next;
        q_reg    <= q_next;
        cnt_reg  <= cnt_next;
        res_reg  <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

// ===== rtl/iir_direct_form_one_filter.sv =====
// Direct form I IIR filter: history RAMs, shared multiply-accumulate and serial divider.
// Filter item: tap products come one at a time from the shared multiplier (one tap product
//   per cycle), then the quotient comes from the 33-step serial divider.
// Fill item: every history entry is written in turn; offset item: each RAM entry is read,
//   modified and written back in turn. One item is worked on at a time.
// Reset (aresetn low, synchronous) restores b0 = a0 = 1.0, other coefficients 0,
//   and marks every history entry invalid so it reads as zero; no clearing pass.
module iir_direct_form_one_filter #(
    parameter int ORDER = iirdf1_pkg::ORDER_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [31:0]                           s_tdata,  // [31:0] value
    input  logic [1:0]                            s_tuser,  // [1:0] cmd
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [31:0] newest_output, [32] saturated, [33] divide_by_zero, [39:34] zero
    output logic [39:0]                           m_tdata,
    input  logic                                  cfg_wr_en,
    input  logic [iirdf1_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [iirdf1_pkg::COEF_W-1:0]         cfg_wr_data
);

    localparam int AW = (ORDER > 1) ? $clog2(ORDER) : 1;
    localparam int SW = iirdf1_pkg::SAMP_W;
    localparam int CW = iirdf1_pkg::COEF_W;
    localparam int PW = iirdf1_pkg::PROD_W;
    localparam int XW = iirdf1_pkg::ACC_W;
    localparam int NC = iirdf1_pkg::NUM_COEF;
    localparam int CFG_IDX_W = iirdf1_pkg::CFG_IDX_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(ORDER - 1);
    localparam logic [1:0]    LAST_TAP  = 2'(ORDER - 1);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_MAC0   = 11'b00000000010,
        S_TAPX   = 11'b00000000100,
        S_TAPY   = 11'b00000001000,
        S_ACC    = 11'b00000010000,
        S_DIVGO  = 11'b00000100000,
        S_DIV    = 11'b00001000000,
        S_FILL   = 11'b00010000000,
        S_ADD_RD = 11'b00100000000,
        S_ADD_WR = 11'b01000000000,
        S_DONE   = 11'b10000000000
    } state_t;

    typedef struct packed {
        logic signed [SW-1:0] val;
        logic                 sat;
    } sum_t;

    function automatic sum_t add_clip(input logic signed [SW-1:0] a,
                                      input logic signed [SW-1:0] b);
        logic signed [SW:0] s;
        sum_t r;
        s = {a[SW-1], a} + {b[SW-1], b};
        if (s[SW] != s[SW-1]) begin
            r.sat = 1'b1;
            r.val = s[SW] ? iirdf1_pkg::SAMP_MIN : iirdf1_pkg::SAMP_MAX;
        end else begin
            r.sat = 1'b0;
            r.val = s[SW-1:0];
        end
        return r;
    endfunction

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == LAST_ADDR) ? '0 : AW'(p + 1'b1);
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        return (p == '0) ? LAST_ADDR : AW'(p - 1'b1);
    endfunction

    // coefficient registers
    logic signed [CW-1:0] num_coef_reg [NC];
    logic signed [CW-1:0] den_coef_reg [NC];

    state_t state_reg, state_next;
    logic signed [SW-1:0] v_reg, v_next;
    logic [AW-1:0]        head_reg, head_next;
    logic [AW-1:0]        ptr_reg, ptr_next;
    logic [1:0]           tap_reg, tap_next;
    logic [ORDER-1:0]     vld_reg, vld_next;
    logic                 rd_vld_reg;
    logic signed [XW-1:0] acc_reg, acc_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic                 prod_vld_reg, prod_vld_next;
    logic                 prod_sub_reg, prod_sub_next;
    logic signed [SW-1:0] newest_reg, newest_next;
    logic                 sat_reg, sat_next;
    logic                 dz_reg, dz_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [39:0]          m_data_reg, m_data_next;

    logic                 ram_rd_en;
    logic                 ram_wr_en;
    logic [AW-1:0]        ram_rd_addr;
    logic [AW-1:0]        ram_wr_addr;
    logic [SW-1:0]        x_wr_data;
    logic [SW-1:0]        y_wr_data;
    logic [SW-1:0]        x_rd_data;
    logic [SW-1:0]        y_rd_data;
    logic signed [SW-1:0] x_hist;
    logic signed [SW-1:0] y_hist;

    logic signed [CW-1:0] coef_sel;
    logic signed [SW-1:0] samp_sel;
    logic [1:0]           tap_idx;
    logic [AW-1:0]        head_dec;
    sum_t                 x_sum;
    sum_t                 y_sum;

    logic                 div_start;
    logic                 div_done;
    iirdf1_pkg::div_res_t div_res;

    iirdf1_ram #(.WIDTH(SW), .DEPTH(ORDER), .ADDR_W(AW)) u_x_hist (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (x_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (x_rd_data)
    );

    iirdf1_ram #(.WIDTH(SW), .DEPTH(ORDER), .ADDR_W(AW)) u_y_hist (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (y_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (y_rd_data)
    );

    iirdf1_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (den_coef_reg[0]),
        .done     (div_done),
        .res      (div_res)
    );

    // entries never written since reset read as zero
    assign x_hist   = rd_vld_reg ? x_rd_data : '0;
    assign y_hist   = rd_vld_reg ? y_rd_data : '0;
    assign tap_idx  = 2'(tap_reg + 2'd1);
    assign head_dec = ptr_dec(head_reg);
    assign x_sum    = add_clip(x_hist, v_reg);
    assign y_sum    = add_clip(y_hist, v_reg);
    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next    = state_reg;
        v_next        = v_reg;
        head_next     = head_reg;
        ptr_next      = ptr_reg;
        tap_next      = tap_reg;
        vld_next      = vld_reg;
        newest_next   = newest_reg;
        sat_next      = sat_reg;
        dz_next       = dz_reg;
        m_tvalid_next = m_tvalid_reg;
        m_data_next   = m_data_reg;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = ptr_reg;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = ptr_reg;
        x_wr_data     = v_reg;
        y_wr_data     = v_reg;
        coef_sel      = '0;
        samp_sel      = '0;
        prod_vld_next = 1'b0;
        prod_sub_next = 1'b0;
        div_start     = 1'b0;

        if (prod_vld_reg) begin
            acc_next = prod_sub_reg ? XW'(acc_reg - XW'(prod_reg))
                                    : XW'(acc_reg + XW'(prod_reg));
        end else begin
            acc_next = acc_reg;
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    v_next   = s_tdata;
                    sat_next = 1'b0;
                    dz_next  = 1'b0;
                    acc_next = '0;
                    tap_next = '0;
                    case (s_tuser)
                        iirdf1_pkg::CMD_FILTER: begin
                            ptr_next   = head_reg;
                            state_next = S_MAC0;
                        end
                        iirdf1_pkg::CMD_FILL: begin
                            ptr_next   = '0;
                            state_next = S_FILL;
                        end
                        iirdf1_pkg::CMD_ADD: begin
                            ptr_next   = '0;
                            state_next = S_ADD_RD;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_MAC0: begin
                coef_sel      = num_coef_reg[0];
                samp_sel      = v_reg;
                prod_vld_next = 1'b1;
                ram_rd_en     = 1'b1;
                ptr_next      = ptr_inc(ptr_reg);
                state_next    = S_TAPX;
            end
            S_TAPX: begin
                coef_sel      = num_coef_reg[tap_idx];
                samp_sel      = x_hist;
                prod_vld_next = 1'b1;
                state_next    = S_TAPY;
            end
            S_TAPY: begin
                coef_sel      = den_coef_reg[tap_idx];
                samp_sel      = y_hist;
                prod_vld_next = 1'b1;
                prod_sub_next = 1'b1;
                if (tap_reg == LAST_TAP) begin
                    state_next = S_ACC;
                end else begin
                    ram_rd_en  = 1'b1;
                    ptr_next   = ptr_inc(ptr_reg);
                    tap_next   = tap_idx;
                    state_next = S_TAPX;
                end
            end
            S_ACC: begin
                // last product lands in the accumulator here
                state_next = S_DIVGO;
            end
            S_DIVGO: begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    // shift histories by moving the head back one entry
                    ram_wr_en          = 1'b1;
                    ram_wr_addr        = head_dec;
                    y_wr_data          = div_res.quot;
                    head_next          = head_dec;
                    vld_next[head_dec] = 1'b1;
                    newest_next        = div_res.quot;
                    sat_next           = div_res.sat;
                    dz_next            = div_res.dz;
                    state_next         = S_DONE;
                end
            end
            S_FILL: begin
                ram_wr_en         = 1'b1;
                vld_next[ptr_reg] = 1'b1;
                newest_next       = v_reg;
                if (ptr_reg == LAST_ADDR) begin
                    state_next = S_DONE;
                end else begin
                    ptr_next = ptr_inc(ptr_reg);
                end
            end
            S_ADD_RD: begin
                ram_rd_en  = 1'b1;
                state_next = S_ADD_WR;
            end
            S_ADD_WR: begin
                ram_wr_en         = 1'b1;
                x_wr_data         = x_sum.val;
                y_wr_data         = y_sum.val;
                vld_next[ptr_reg] = 1'b1;
                sat_next          = sat_reg | x_sum.sat | y_sum.sat;
                if (ptr_reg == head_reg) begin
                    newest_next = y_sum.val;
                end
                if (ptr_reg == LAST_ADDR) begin
                    state_next = S_DONE;
                end else begin
                    ptr_next   = ptr_inc(ptr_reg);
                    state_next = S_ADD_RD;
                end
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = {6'd0, dz_reg, sat_reg, newest_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        prod_next = coef_sel * samp_sel;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            vld_reg      <= '0;
            newest_reg   <= '0;
            prod_vld_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int k = 0; k < NC; k++) begin
                num_coef_reg[k] <= (k == 0) ? iirdf1_pkg::COEF_ONE : '0;
                den_coef_reg[k] <= (k == 0) ? iirdf1_pkg::COEF_ONE : '0;
            end
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            vld_reg      <= vld_next;
            newest_reg   <= newest_next;
            prod_vld_reg <= prod_vld_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                for (int k = 0; k < NC; k++) begin
                    if (cfg_addr == CFG_IDX_W'(iirdf1_pkg::CFG_NUM_COEF_0 + k)) begin
                        num_coef_reg[k] <= cfg_wr_data;
                    end
                    if (cfg_addr == CFG_IDX_W'(iirdf1_pkg::CFG_DEN_COEF_0 + k)) begin
                        den_coef_reg[k] <= cfg_wr_data;
                    end
                end
            end
        end
        v_reg        <= v_next;
        ptr_reg      <= ptr_next;
        tap_reg      <= tap_next;
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
        prod_sub_reg <= prod_sub_next;
        sat_reg      <= sat_next;
        dz_reg       <= dz_next;
        m_data_reg   <= m_data_next;
        if (ram_rd_en) begin
            rd_vld_reg <= vld_reg[ram_rd_addr];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken again right after a transfer");

    a_div_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside its wait state");

    a_ram_write_states: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr_en |-> (state_reg == S_FILL || state_reg == S_ADD_WR || state_reg == S_DIV))
        else $error("history write outside a writing state");

    a_head_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg <= LAST_ADDR)
        else $error("history head beyond depth");

    a_dz_gives_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (div_done && div_res.dz) |-> (div_res.quot == '0 && !div_res.sat))
        else $error("zero divisor produced a nonzero or clipped result");
`endif

endmodule
